### rtl/pixel_chroma_color_classifier_unit_macros.svh
// Assertion macros shared by the classifier RTL.
// Each macro checks one property on the rising clock edge, outside reset.
`ifndef PIXEL_CHROMA_COLOR_CLASSIFIER_UNIT_MACROS_SVH
`define PIXEL_CHROMA_COLOR_CLASSIFIER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCCC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pccc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chroma classifier package
// Register indexes, reset values, fixed-point weights and the channel
// gain and bias helper shared by the classifier RTL.
// ----------------------------------------------------------------------------
package pccc_pkg;

	typedef enum logic [2:0] {
		REG_CHANNEL_GAIN      = 3'd0,
		REG_CHANNEL_BIAS      = 3'd1,
		REG_RED_CHROMA_LOW    = 3'd2,
		REG_RED_CHROMA_HIGH   = 3'd3,
		REG_GREEN_CHROMA_LOW  = 3'd4,
		REG_GREEN_CHROMA_HIGH = 3'd5
	} cfg_reg_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int GAIN_W      = 10;
	localparam int BIAS_W      = 16;
	localparam int BOUND_W     = 9;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	localparam logic [GAIN_W-1:0]  GAIN_RESET       = 10'd77;
	localparam logic [BIAS_W-1:0]  BIAS_RESET       = 16'd22400;
	localparam logic [BOUND_W-1:0] RED_LOW_RESET    = 9'd145;
	localparam logic [BOUND_W-1:0] RED_HIGH_RESET   = 9'd470;
	localparam logic [BOUND_W-1:0] GREEN_LOW_RESET  = 9'd95;
	localparam logic [BOUND_W-1:0] GREEN_HIGH_RESET = 9'd110;

	localparam logic [13:0] W_BLUE  = 14'd1868;
	localparam logic [13:0] W_GREEN = 14'd9617;
	localparam logic [13:0] W_RED   = 14'd4899;
	localparam logic [22:0] LUMA_ROUND = 23'd8192;
	localparam logic signed [23:0] W_CR      = 24'sd11682;
	localparam logic signed [23:0] CR_OFFSET = 24'sd2105344;

	typedef logic [17:0] gain_prod_t;

	// Adds bias and rounding to a gain product, drops eight fraction bits and
	// saturates to eight bits.
	function automatic logic [7:0] adjust_channel(input gain_prod_t prod,
		input logic [BIAS_W-1:0] bias);
		logic [18:0] sum;
		sum = 19'(prod) + 19'(bias) + 19'd128;
		if (|sum[18:16]) begin
			return 8'hFF;
		end
		return sum[15:8];
	endfunction

endpackage

### rtl/pixel_chroma_color_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel chroma color classifier
// Applies gain and bias to a BGR pixel, computes BT.601 red chroma and tests
// it against a red and a green window.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while the output side does not stall
// and returns one result per pixel, in order. Six pipeline stages (gain
// multiply, bias and saturate, luma multiply, luma sum and difference,
// chroma multiply, chroma saturate) and an output register carry each
// pixel; each stage holds its own valid bit and holds while it is full and
// the next stage cannot take it, so a stall at the output fills the bubbles
// first. Registers are to be written through the configuration port only
// while no pixel is in flight; the block itself does not enforce this.
module pixel_chroma_color_classifier_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pccc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pccc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// Fields from bit 0: pixel_blue[7:0], pixel_green[7:0], pixel_red[7:0].
	input  logic [pccc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// Fields from bit 0: chroma_red[7:0], red_mask, green_mask, zero padding.
	output logic [pccc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	import pccc_pkg::*;

	logic [GAIN_W-1:0]  channel_gain_q;
	logic [BIAS_W-1:0]  channel_bias_q;
	logic [BOUND_W-1:0] red_low_q;
	logic [BOUND_W-1:0] red_high_q;
	logic [BOUND_W-1:0] green_low_q;
	logic [BOUND_W-1:0] green_high_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_out;

	gain_prod_t prod_b_s1, prod_g_s1, prod_r_s1;
	logic [7:0] adj_b_s2, adj_g_s2, adj_r_s2;
	logic [21:0] luma_b_s3, luma_g_s3, luma_r_s3;
	logic [7:0] red_s3;
	logic signed [8:0] diff_s4;
	logic signed [23:0] cr_prod_s5;
	logic [7:0] cr_s6;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [22:0] luma_sum;
	logic [7:0] luma;
	logic signed [23:0] diff_ext;
	logic signed [23:0] cr_sum;
	logic [7:0] cr_sat;
	logic [BOUND_W-1:0] cr_wide;
	logic red_hit, green_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_gain_q <= GAIN_RESET;
			channel_bias_q <= BIAS_RESET;
			red_low_q      <= RED_LOW_RESET;
			red_high_q     <= RED_HIGH_RESET;
			green_low_q    <= GREEN_LOW_RESET;
			green_high_q   <= GREEN_HIGH_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CHANNEL_GAIN:      channel_gain_q <= cfg_data[GAIN_W-1:0];
				REG_CHANNEL_BIAS:      channel_bias_q <= cfg_data[BIAS_W-1:0];
				REG_RED_CHROMA_LOW:    red_low_q      <= cfg_data[BOUND_W-1:0];
				REG_RED_CHROMA_HIGH:   red_high_q     <= cfg_data[BOUND_W-1:0];
				REG_GREEN_CHROMA_LOW:  green_low_q    <= cfg_data[BOUND_W-1:0];
				REG_GREEN_CHROMA_HIGH: green_high_q   <= cfg_data[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	assign rdy_out = !out_valid_q || m_axis_tready;
	assign rdy_s6  = !v_s6 || rdy_out;
	assign rdy_s5  = !v_s5 || rdy_s6;
	assign rdy_s4  = !v_s4 || rdy_s5;
	assign rdy_s3  = !v_s3 || rdy_s4;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1        <= s_axis_tvalid;
			if (rdy_s2)  v_s2        <= v_s1;
			if (rdy_s3)  v_s3        <= v_s2;
			if (rdy_s4)  v_s4        <= v_s3;
			if (rdy_s5)  v_s5        <= v_s4;
			if (rdy_s6)  v_s6        <= v_s5;
			if (rdy_out) out_valid_q <= v_s6;
		end
	end

	assign luma_sum = 23'(luma_b_s3) + 23'(luma_g_s3) + 23'(luma_r_s3) + LUMA_ROUND;
	assign luma     = luma_sum[21:14];
	assign diff_ext = 24'(diff_s4);
	assign cr_sum   = cr_prod_s5 + CR_OFFSET;

	always_comb begin
		if (cr_sum[23]) begin
			cr_sat = 8'd0;
		end else if (cr_sum[22]) begin
			cr_sat = 8'hFF;
		end else begin
			cr_sat = cr_sum[21:14];
		end
	end

	assign cr_wide   = BOUND_W'(cr_s6);
	assign red_hit   = (cr_wide > red_low_q) && (cr_wide < red_high_q);
	assign green_hit = (cr_wide > green_low_q) && (cr_wide < green_high_q);

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			prod_b_s1 <= 18'(s_axis_tdata[7:0]) * 18'(channel_gain_q);
			prod_g_s1 <= 18'(s_axis_tdata[15:8]) * 18'(channel_gain_q);
			prod_r_s1 <= 18'(s_axis_tdata[23:16]) * 18'(channel_gain_q);
		end
		if (rdy_s2 && v_s1) begin
			adj_b_s2 <= adjust_channel(prod_b_s1, channel_bias_q);
			adj_g_s2 <= adjust_channel(prod_g_s1, channel_bias_q);
			adj_r_s2 <= adjust_channel(prod_r_s1, channel_bias_q);
		end
		if (rdy_s3 && v_s2) begin
			luma_b_s3 <= 22'(adj_b_s2) * 22'(W_BLUE);
			luma_g_s3 <= 22'(adj_g_s2) * 22'(W_GREEN);
			luma_r_s3 <= 22'(adj_r_s2) * 22'(W_RED);
			red_s3    <= adj_r_s2;
		end
		if (rdy_s4 && v_s3) begin
			diff_s4 <= $signed({1'b0, red_s3}) - $signed({1'b0, luma});
		end
		if (rdy_s5 && v_s4) begin
			cr_prod_s5 <= diff_ext * W_CR;
		end
		if (rdy_s6 && v_s5) begin
			cr_s6 <= cr_sat;
		end
		if (rdy_out && v_s6) begin
			out_data_q <= {6'd0, green_hit, red_hit, cr_s6};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`include "pixel_chroma_color_classifier_unit_macros.svh"

	`PCCC_ASSERT_SAME(a_full_when_blocked, !s_axis_tready,
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && out_valid_q && !m_axis_tready,
		"input blocked while the pipeline has a free stage")
	`PCCC_ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, v_s1,
		"accepted pixel did not enter the first stage")
	`PCCC_ASSERT_NEXT(a_s3_holds, v_s3 && !rdy_s4, v_s3 && $stable(luma_b_s3) && $stable(red_s3),
		"stalled luma stage lost or changed its contents")

endmodule

### verif/chroma_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chroma classifier result checker
// Watches the configuration port and both streams of the classifier. It keeps
// its own copy of the registers, works out the chroma and both mask bits for
// every pixel taken in, and compares each result that leaves the block with
// the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module chroma_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pccc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pccc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	// Fields from bit 0: pixel_blue[7:0], pixel_green[7:0], pixel_red[7:0].
	input  logic [pccc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// Fields from bit 0: chroma_red[7:0], red_mask, green_mask, zero padding.
	input  logic [pccc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output int                                error_count,
	output int                                outstanding
);

	import pccc_pkg::*;

	localparam int LUMA_WEIGHT_B = 1868;
	localparam int LUMA_WEIGHT_G = 9617;
	localparam int LUMA_WEIGHT_R = 4899;
	localparam int CHROMA_WEIGHT = 11682;
	localparam int FRAC_BITS     = 14;
	localparam int MAX_REPORTS   = 50;

	typedef struct packed {
		logic [7:0] chroma_red;
		logic       red_mask;
		logic       green_mask;
	} chroma_result_t;

	logic [GAIN_W-1:0]  gain_q;
	logic [BIAS_W-1:0]  bias_q;
	logic [BOUND_W-1:0] red_low_q;
	logic [BOUND_W-1:0] red_high_q;
	logic [BOUND_W-1:0] green_low_q;
	logic [BOUND_W-1:0] green_high_q;

	chroma_result_t pending_results[$];
	chroma_result_t due;
	chroma_result_t seen;
	int             result_index;

	initial begin
		error_count  = 0;
		outstanding  = 0;
		result_index = 0;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_REPORTS) begin
			$display("ERROR at %0t ns, result %0d: %s", $time, result_index, msg);
		end
		error_count++;
	endtask

	function automatic logic [7:0] scale_channel(input logic [7:0] ch);
		logic [19:0] acc;
		acc = 20'(ch) * 20'(gain_q) + 20'(bias_q) + 20'd128;
		if (acc[19:8] > 12'd255) begin
			return 8'hFF;
		end
		return acc[15:8];
	endfunction

	function automatic chroma_result_t classify_pixel(input logic [IN_TDATA_W-1:0] px);
		chroma_result_t res;
		int blue;
		int green;
		int red;
		int luma;
		int cr_sum;
		int cr;
		blue  = int'(scale_channel(px[7:0]));
		green = int'(scale_channel(px[15:8]));
		red   = int'(scale_channel(px[23:16]));
		luma  = (blue * LUMA_WEIGHT_B + green * LUMA_WEIGHT_G + red * LUMA_WEIGHT_R
			+ (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
		cr_sum = (red - luma) * CHROMA_WEIGHT + (128 << FRAC_BITS) + (1 << (FRAC_BITS - 1));
		if (cr_sum < 0) begin
			cr = 0;
		end else begin
			cr = cr_sum >>> FRAC_BITS;
			if (cr > 255) begin
				cr = 255;
			end
		end
		res.chroma_red = 8'(cr);
		res.red_mask   = (cr > int'(red_low_q)) && (cr < int'(red_high_q));
		res.green_mask = (cr > int'(green_low_q)) && (cr < int'(green_high_q));
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q       = GAIN_RESET;
			bias_q       = BIAS_RESET;
			red_low_q    = RED_LOW_RESET;
			red_high_q   = RED_HIGH_RESET;
			green_low_q  = GREEN_LOW_RESET;
			green_high_q = GREEN_HIGH_RESET;
			pending_results.delete();
			outstanding  = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.chroma_red = m_axis_tdata[7:0];
				seen.red_mask   = m_axis_tdata[8];
				seen.green_mask = m_axis_tdata[9];
				if (pending_results.size() == 0) begin
					report_mismatch("result transaction with no pixel outstanding");
				end else begin
					due = pending_results.pop_front();
					if (seen.chroma_red !== due.chroma_red) begin
						report_mismatch($sformatf("chroma_red is %0d, predicted %0d",
							seen.chroma_red, due.chroma_red));
					end
					if (seen.red_mask !== due.red_mask) begin
						report_mismatch($sformatf("red_mask is %b, predicted %b",
							seen.red_mask, due.red_mask));
					end
					if (seen.green_mask !== due.green_mask) begin
						report_mismatch($sformatf("green_mask is %b, predicted %b",
							seen.green_mask, due.green_mask));
					end
				end
				result_index++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pending_results.push_back(classify_pixel(s_axis_tdata));
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_CHANNEL_GAIN: begin
						gain_q = cfg_data[GAIN_W-1:0];
					end
					REG_CHANNEL_BIAS: begin
						bias_q = cfg_data[BIAS_W-1:0];
					end
					REG_RED_CHROMA_LOW: begin
						red_low_q = cfg_data[BOUND_W-1:0];
					end
					REG_RED_CHROMA_HIGH: begin
						red_high_q = cfg_data[BOUND_W-1:0];
					end
					REG_GREEN_CHROMA_LOW: begin
						green_low_q = cfg_data[BOUND_W-1:0];
					end
					REG_GREEN_CHROMA_HIGH: begin
						green_high_q = cfg_data[BOUND_W-1:0];
					end
					default: begin
					end
				endcase
			end
			outstanding = pending_results.size();
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chroma classifier testbench
// Drives pixels into the classifier under a series of register settings:
// the reset values, unity and extreme gains, saturating bias, empty windows
// and bounds above the chroma range, then random settings. Both stream sides
// pause in random bursts, and one long output stall backs up the pipeline.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

	import pccc_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 12;
	localparam int STALL_LIMIT  = 2000;
	localparam int LONG_HOLD    = 80;
	localparam int RANDOM_ITEMS = 80;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    cfg_wr_en     = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0]   cfg_data      = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;

	int error_count;
	int outstanding;

	bit released     = 1'b0;
	bit calm         = 1'b0;
	bit hold_request = 1'b0;
	bit hold_used    = 1'b0;
	int hold_left    = 0;
	int rx_gap_left  = 0;
	int quiet_cycles = 0;

	always #CLK_HALF clk = ~clk;

	pixel_chroma_color_classifier_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	chroma_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.error_count   (error_count),
		.outstanding   (outstanding)
	);

	// The output side takes results with random pauses, and once holds off
	// long enough for the pipeline to fill and stall its input.
	always @(posedge clk) begin
		if (!released) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (hold_request && !hold_used) begin
			hold_used = 1'b1;
			hold_left = LONG_HOLD - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_gap_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_gap_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 9) == 0) begin
				rx_gap_left = $urandom_range(1, 12);
			end
		end
	end

	always @(posedge clk) begin
		if (released) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_wr_en) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Writes every register; with junk set, the unused upper data bits carry
	// random values that the block must drop. Unmapped indexes are written
	// too and must leave the settings alone.
	task automatic program_classifier(input logic [GAIN_W-1:0] gain,
		input logic [BIAS_W-1:0] bias, input logic [BOUND_W-1:0] red_low,
		input logic [BOUND_W-1:0] red_high, input logic [BOUND_W-1:0] green_low,
		input logic [BOUND_W-1:0] green_high, input bit junk);
		logic [CFG_DATA_W-1:0] upper;
		upper = junk ? CFG_DATA_W'($urandom()) : '0;
		write_reg(REG_CHANNEL_GAIN, {upper[CFG_DATA_W-1:GAIN_W], gain});
		write_reg(REG_CHANNEL_BIAS, bias);
		write_reg(REG_RED_CHROMA_LOW, {upper[CFG_DATA_W-1:BOUND_W], red_low});
		write_reg(REG_RED_CHROMA_HIGH, {upper[CFG_DATA_W-2:BOUND_W-1], red_high});
		write_reg(REG_GREEN_CHROMA_LOW, {upper[CFG_DATA_W-3:BOUND_W-2], green_low});
		write_reg(REG_GREEN_CHROMA_HIGH, {upper[CFG_DATA_W-4:BOUND_W-3], green_high});
		write_reg(REG_SPARE_A, CFG_DATA_W'($urandom()));
		write_reg(REG_SPARE_B, CFG_DATA_W'($urandom()));
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_pixel(input logic [IN_TDATA_W-1:0] px);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_corner_pixels();
		logic [IN_TDATA_W-1:0] corners[12];
		corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hAA55AA, 24'h55AA55,
			24'h808080, 24'h7F7F7F};
		foreach (corners[i]) begin
			send_pixel(corners[i]);
		end
	endtask

	task automatic send_random_pixels(input int count);
		repeat (count) begin
			send_pixel(IN_TDATA_W'($urandom()));
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// The first edge lets the checker count the last transaction taken in.
	task automatic wait_idle();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [BOUND_W-1:0] pick_bound();
		if ($urandom_range(0, 3) == 0) begin
			return BOUND_W'($urandom_range(0, 511));
		end
		return BOUND_W'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [GAIN_W-1:0]  gain;
		logic [BIAS_W-1:0]  bias;
		logic [BOUND_W-1:0] red_low;
		logic [BOUND_W-1:0] green_low;
		logic [BOUND_W-1:0] red_high;
		logic [BOUND_W-1:0] green_high;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		released = 1'b1;
		@(posedge clk);

		write_reg(REG_SPARE_A, CFG_DATA_W'($urandom()));
		cfg_wr_en <= 1'b0;
		send_corner_pixels();
		send_random_pixels(RANDOM_ITEMS);
		wait_idle();

		program_classifier(10'd256, 16'd0, 9'd128, 9'd511, 9'd0, 9'd129, 1'b0);
		send_corner_pixels();
		send_random_pixels(RANDOM_ITEMS);
		wait_idle();

		program_classifier(10'd1023, 16'd0, 9'd255, 9'd511, 9'd511, 9'd0, 1'b1);
		send_random_pixels(50);
		wait_idle();

		program_classifier(10'd0, 16'd65535, 9'd127, 9'd129, 9'd128, 9'd129, 1'b1);
		send_random_pixels(50);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			case ($urandom_range(0, 2))
				0: gain = GAIN_W'($urandom_range(200, 320));
				1: gain = GAIN_W'($urandom_range(0, 1023));
				default: gain = GAIN_W'($urandom_range(60, 200));
			endcase
			if ($urandom_range(0, 3) == 0) begin
				bias = BIAS_W'($urandom_range(0, 65535));
			end else begin
				bias = BIAS_W'($urandom_range(0, 8191));
			end
			red_low    = pick_bound();
			green_low  = pick_bound();
			red_high   = $urandom_range(0, 1) ? pick_bound()
				: BOUND_W'(red_low + $urandom_range(0, 120));
			green_high = $urandom_range(0, 1) ? pick_bound()
				: BOUND_W'(green_low + $urandom_range(0, 120));
			if (phase == 2) begin
				hold_request = 1'b1;
			end
			if (phase == 5) begin
				calm = 1'b1;
			end
			program_classifier(gain, bias, red_low, red_high, green_low, green_high, 1'b1);
			send_random_pixels(RANDOM_ITEMS);
			wait_idle();
		end

		if (error_count == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/pccc_pkg.sv
rtl/pixel_chroma_color_classifier_unit.sv
verif/chroma_result_checker.sv
verif/tb.sv
